### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("%m: lbl");

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("%m: lbl");

// An implication checked at every clock edge, reset included.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("%m: lbl");

`endif

### design/wtr_pkg.sv
`timescale 1ns / 1ps
package wtr_pkg;

  localparam int TARGET_BITS = 256;
  localparam int WTR_MUL_CELLS = 34;
  localparam int WTR_DIV_CELLS = TARGET_BITS;
  localparam int WTR_LATENCY = 1 + WTR_MUL_CELLS + WTR_DIV_CELLS + 3;

  // Configuration register indexes.
  localparam logic [2:0] REG_TIMESPAN = 3'd0;
  localparam logic [2:0] REG_NO_RETARGET = 3'd1;
  localparam logic [2:0] REG_LIMIT3 = 3'd2;
  localparam logic [2:0] REG_LIMIT2 = 3'd3;
  localparam logic [2:0] REG_LIMIT1 = 3'd4;
  localparam logic [2:0] REG_LIMIT0 = 3'd5;

  // Control that travels alongside each transaction.
  typedef struct packed {
    logic        valid;
    logic        bypass;
    logic [31:0] prev;
  } ctl_t;

endpackage

### design/wtr_mul_cell.sv
`timescale 1ns / 1ps
module wtr_mul_cell
  import wtr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl_in,
  input  logic [TARGET_BITS-1:0] acc_in,
  input  logic [TARGET_BITS-1:0] mcand_in,
  input  logic [33:0]            mplier_in,
  output ctl_t                   ctl_out,
  output logic [TARGET_BITS-1:0] acc_out,
  output logic [TARGET_BITS-1:0] mcand_out,
  output logic [33:0]            mplier_out
);

  // One shift-and-add step: add the multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.bypass <= ctl_in.bypass;
    ctl_out.prev <= ctl_in.prev;
    acc_out <= mplier_in[0] ? acc_in + mcand_in : acc_in;
    mcand_out <= {mcand_in[TARGET_BITS-2:0], 1'b0};
    mplier_out <= {1'b0, mplier_in[33:1]};
  end

endmodule

### design/wtr_div_cell.sv
`timescale 1ns / 1ps
module wtr_div_cell
  import wtr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            divisor,
  input  ctl_t                   ctl_in,
  input  logic [31:0]            rem_in,
  input  logic [TARGET_BITS-1:0] work_in,
  output ctl_t                   ctl_out,
  output logic [31:0]            rem_out,
  output logic [TARGET_BITS-1:0] work_out
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        qbit;

  // One restoring division step; quotient bits shift in as dividend bits shift out.
  always_comb begin
    trial = {rem_in, work_in[TARGET_BITS-1]};
    diff = trial - {1'b0, divisor};
    qbit = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.bypass <= ctl_in.bypass;
    ctl_out.prev <= ctl_in.prev;
    rem_out <= qbit ? diff[31:0] : trial[31:0];
    work_out <= {work_in[TARGET_BITS-2:0], qbit};
  end

endmodule

### design/wtr_pack.sv
`timescale 1ns / 1ps
module wtr_pack
  import wtr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   div_zero,
  input  logic [TARGET_BITS-1:0] limit,
  input  ctl_t                   ctl_in,
  input  logic [TARGET_BITS-1:0] quot_in,
  output logic                   done,
  output logic [31:0]            next_compact
);

  ctl_t                   ctl1, ctl2;
  logic [TARGET_BITS-1:0] val1, val2;
  logic [TARGET_BITS-1:0] raw;
  logic [5:0]             size_next, size2;
  logic [5:0]             size_fin;
  logic [23:0]            mant;
  logic [31:0]            compact_next;

  // A zero divisor gives an all-ones quotient before the cap.
  assign raw = div_zero ? {TARGET_BITS{1'b1}} : quot_in;

  // Byte length of the capped value.
  always_comb begin
    size_next = 6'd0;
    for (int i = 0; i < TARGET_BITS / 8; i++) begin
      if (val1[8*i +: 8] != 8'd0) size_next = 6'(i + 1);
    end
  end

  // Take the top three bytes; move up a byte when the mantissa sign bit would be set.
  always_comb begin
    if (size2 <= 6'd3) begin
      mant = 24'(val2[23:0] << {6'd3 - size2, 3'b000});
    end else begin
      mant = 24'(val2 >> {size2 - 6'd3, 3'b000});
    end
    size_fin = size2;
    if (mant[23]) begin
      mant = {8'd0, mant[23:8]};
      size_fin = size2 + 6'd1;
    end
    compact_next = ctl2.bypass ? ctl2.prev : {8'(size_fin), 1'b0, mant[22:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      done <= 1'b0;
    end else begin
      ctl1.valid <= ctl_in.valid;
      ctl2.valid <= ctl1.valid;
      done <= ctl2.valid;
    end
    ctl1.bypass <= ctl_in.bypass;
    ctl1.prev <= ctl_in.prev;
    ctl2.bypass <= ctl1.bypass;
    ctl2.prev <= ctl1.prev;
    val1 <= (raw > limit) ? limit : raw;
    val2 <= val1;
    size2 <= size_next;
    next_compact <= compact_next;
  end

endmodule

### design/work_target_retarget.sv
`timescale 1ns / 1ps
// Channel   | Handshake        | Payload
// input     | start / busy     | prev_compact, window_end_time, window_start_time
// result    | done             | next_compact
// config    | cfg_we           | cfg_index, cfg_data
//
// A new transaction is taken every cycle; busy is always low.
// Each result passes through one input stage, 34 multiply cells,
// 256 divide cells (one quotient bit each) and three stages of capping
// and compact encoding.
// Reset clears the pipeline valid bits and loads register defaults.
// The receiver cannot stall, so the row of cells never holds.
module work_target_retarget
  import wtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] prev_compact,
  input  logic [31:0] window_end_time,
  input  logic [31:0] window_start_time,
  output logic        done,
  output logic [31:0] next_compact,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [31:0] target_timespan;
  logic        no_retarget;
  logic [63:0] limit_word3, limit_word2, limit_word1, limit_word0;

  ctl_t                   mctl [0:WTR_MUL_CELLS];
  logic [TARGET_BITS-1:0] macc [0:WTR_MUL_CELLS];
  logic [TARGET_BITS-1:0] mcand [0:WTR_MUL_CELLS];
  logic [33:0]            mplier [0:WTR_MUL_CELLS];
  ctl_t                   dctl [0:WTR_DIV_CELLS];
  logic [31:0]            drem [0:WTR_DIV_CELLS];
  logic [TARGET_BITS-1:0] dwork [0:WTR_DIV_CELLS];

  logic [TARGET_BITS-1:0] expanded;
  logic [7:0]             exp_size;
  logic [34:0]            span, lo, hi, clamped;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_timespan <= 32'd1209600;
      no_retarget <= 1'b0;
      limit_word3 <= 64'h0000_0000_ffff_ffff;
      limit_word2 <= '1;
      limit_word1 <= '1;
      limit_word0 <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMESPAN: target_timespan <= cfg_data[31:0];
        REG_NO_RETARGET: no_retarget <= cfg_data[0];
        REG_LIMIT3: limit_word3 <= cfg_data;
        REG_LIMIT2: limit_word2 <= cfg_data;
        REG_LIMIT1: limit_word1 <= cfg_data;
        REG_LIMIT0: limit_word0 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Expand the compact target to full width.
  always_comb begin
    exp_size = prev_compact[31:24];
    expanded = '0;
    if (exp_size <= 8'd3) begin
      expanded = TARGET_BITS'(prev_compact[22:0] >> {8'd3 - exp_size, 3'b000});
    end else if (exp_size < 8'd35) begin
      expanded = TARGET_BITS'(prev_compact[22:0]) << {exp_size - 8'd3, 3'b000};
    end
  end

  // Clamp the signed span between a quarter and four times the target span.
  always_comb begin
    span = 35'({1'b0, window_end_time}) - 35'({1'b0, window_start_time});
    lo = 35'(target_timespan[31:2]);
    hi = {1'b0, target_timespan, 2'b00};
    clamped = span;
    if ($signed(clamped) < $signed(lo)) clamped = lo;
    if ($signed(clamped) > $signed(hi)) clamped = hi;
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      mctl[0].valid <= 1'b0;
    end else begin
      mctl[0].valid <= start & ~busy;
    end
    mctl[0].bypass <= no_retarget;
    mctl[0].prev <= prev_compact;
    macc[0] <= '0;
    mcand[0] <= expanded;
    mplier[0] <= clamped[33:0];
  end

  // Multiply cells.
  for (genvar g = 0; g < WTR_MUL_CELLS; g++) begin : g_mul
    wtr_mul_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl_in     (mctl[g]),
      .acc_in     (macc[g]),
      .mcand_in   (mcand[g]),
      .mplier_in  (mplier[g]),
      .ctl_out    (mctl[g+1]),
      .acc_out    (macc[g+1]),
      .mcand_out  (mcand[g+1]),
      .mplier_out (mplier[g+1])
    );
  end

  assign dctl[0] = mctl[WTR_MUL_CELLS];
  assign drem[0] = '0;
  assign dwork[0] = macc[WTR_MUL_CELLS];

  // Divide cells.
  for (genvar g = 0; g < WTR_DIV_CELLS; g++) begin : g_div
    wtr_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .divisor  (target_timespan),
      .ctl_in   (dctl[g]),
      .rem_in   (drem[g]),
      .work_in  (dwork[g]),
      .ctl_out  (dctl[g+1]),
      .rem_out  (drem[g+1]),
      .work_out (dwork[g+1])
    );
  end

  wtr_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .div_zero     (target_timespan == 32'd0),
    .limit        ({limit_word3, limit_word2, limit_word1, limit_word0}),
    .ctl_in       (dctl[WTR_DIV_CELLS]),
    .quot_in      (dwork[WTR_DIV_CELLS]),
    .done         (done),
    .next_compact (next_compact)
  );

endmodule

### design/wtr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wtr_checker
  import wtr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] prev_compact,
  input logic [31:0] window_end_time,
  input logic [31:0] window_start_time,
  input logic        done,
  input logic [31:0] next_compact,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [63:0] cfg_data
);

  // The pipeline never refuses a transaction.
  `ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)

  // Reset empties the pipeline.
  `ASSERT_NEXT(a_reset_clears, clk, rst, !done)

  // Every result traces back to a transaction taken a fixed time earlier.
  `ASSERT_IMPL(a_result_has_source, clk, rst, done, $past(start, WTR_LATENCY))

endmodule

bind work_target_retarget wtr_checker u_wtr_checker (.*);
